### design/fixed_block_free_list_core_defines.svh
// Assertion macros used by the checker file of the free list core.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef FIXED_BLOCK_FREE_LIST_CORE_DEFINES_SVH
`define FIXED_BLOCK_FREE_LIST_CORE_DEFINES_SVH

// The consequence must hold in the same cycle as the condition.
`define FBFL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("free list check failed");

// The consequence must hold in the cycle after the condition.
`define FBFL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("free list check failed");

`endif

### design/fbfl_pkg.sv
package fbfl_pkg;

  localparam int MAX_BLOCKS = 1024;
  localparam int ADDR_BITS  = 32;
  localparam int SIZE_BITS  = 16;
  localparam int ALIGN_BITS = 5;
  localparam int STAT_BITS  = 3;
  localparam int OP_BITS    = 2;
  localparam int IDX_BITS   = $clog2(MAX_BLOCKS);
  localparam int COUNT_BITS = $clog2(MAX_BLOCKS + 1);

  localparam logic [SIZE_BITS-1:0]  BLOCK_SIZE_RESET = SIZE_BITS'(64);
  localparam logic [COUNT_BITS-1:0] MAX_COUNT        = COUNT_BITS'(MAX_BLOCKS);

  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [STAT_BITS-1:0]  stat_t;

  localparam logic [OP_BITS-1:0] OP_GROW  = 2'd0;
  localparam logic [OP_BITS-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_BITS-1:0] OP_FREE  = 2'd2;
  localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd3;

  localparam stat_t ST_OK        = 3'd0;
  localparam stat_t ST_EMPTY     = 3'd1;
  localparam stat_t ST_BADREGION = 3'd2;
  localparam stat_t ST_TRUNC     = 3'd3;
  localparam stat_t ST_OVERFLOW  = 3'd4;

endpackage

### design/fixed_block_free_list_core.sv
// Channel  Direction  Handshake              Transaction carries
// in       into core  in_valid / in_stall    operation, block_address and the grow fields
// out      from core  out_valid / out_stall  result_address, status, free_count
// cfg      into core  cfg_we                 cfg_wdata (block size in bytes)
//
// Allocate, free and list reset pass through acceptance, then the registered stack read
// or the hand-over to the output. Grow runs up to three checks, a set-up step, the bit-serial
// divider and a step to cap the count, then writes its blocks (up to 1024) through the memory's
// one write port, then hands over; a failed check ends it early.
// Reset is synchronous: the list empties, the block size returns to 64 and the output drops,
// but the stack memory is not cleared. A stalled output holds its result, and the next
// finished result waits inside the core, stalling the input, until the output is taken.

module fixed_block_free_list_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [fbfl_pkg::OP_BITS-1:0]       operation,
  input  logic [fbfl_pkg::ADDR_BITS-1:0]     block_address,
  input  logic [fbfl_pkg::ADDR_BITS-1:0]     region_start,
  input  logic [fbfl_pkg::ADDR_BITS-1:0]     region_end,
  input  logic [fbfl_pkg::ALIGN_BITS-1:0]    alignment_log2,
  input  logic [fbfl_pkg::SIZE_BITS-1:0]     align_offset,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [fbfl_pkg::ADDR_BITS-1:0]     result_address,
  output logic [fbfl_pkg::STAT_BITS-1:0]     status,
  output logic [fbfl_pkg::COUNT_BITS-1:0]    free_count,
  input  logic                               cfg_we,
  input  logic [fbfl_pkg::SIZE_BITS-1:0]     cfg_wdata
);

  localparam int AW = fbfl_pkg::ADDR_BITS;
  localparam int SW = fbfl_pkg::SIZE_BITS;
  localparam int IW = fbfl_pkg::IDX_BITS;
  localparam int CW = fbfl_pkg::COUNT_BITS;
  // The dividend is the region length, which can reach the whole address space.
  localparam int DW = AW + 1;
  localparam int DCW = $clog2(DW);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ARD  = 4'd1;
  localparam logic [3:0] S_FIN  = 4'd2;
  localparam logic [3:0] S_G1   = 4'd3;
  localparam logic [3:0] S_G2   = 4'd4;
  localparam logic [3:0] S_G3   = 4'd5;
  localparam logic [3:0] S_G4   = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_GN   = 4'd8;
  localparam logic [3:0] S_FILL = 4'd9;

  logic [3:0]            state;
  logic [SW-1:0]         block_size;
  fbfl_pkg::count_t      depth;

  // Captured grow request and intermediate addresses.
  fbfl_pkg::addr_t       g_start;
  fbfl_pkg::addr_t       g_end;
  logic [fbfl_pkg::ALIGN_BITS-1:0] g_lg;
  logic [SW-1:0]         g_off;
  fbfl_pkg::addr_t       g_s;
  fbfl_pkg::addr_t       g_first;
  logic                  g_trunc;

  // Bit-serial divider: dvd shifts the dividend out and the quotient in.
  logic [DW-1:0]         dvd;
  logic [SW-1:0]         drem;
  logic [DCW-1:0]        div_cnt;

  // Fill walk: index goes down from the top entry while the address climbs.
  logic [IW-1:0]         fill_idx;
  fbfl_pkg::addr_t       fill_addr;
  fbfl_pkg::count_t      fill_n;

  // Finished result waiting for the output register.
  fbfl_pkg::addr_t       res_addr;
  fbfl_pkg::stat_t       res_status;

  logic                  accept;
  logic                  out_free;
  logic                  out_load;
  logic                  list_full;
  logic                  list_empty;

  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  fbfl_pkg::addr_t       ram_wdata;
  logic [IW-1:0]         ram_raddr;
  fbfl_pkg::addr_t       ram_rdata;

  logic [AW:0]           s_sum;
  logic                  g1_bad;
  fbfl_pkg::addr_t       amask;
  fbfl_pkg::addr_t       adj;
  logic [AW:0]           a_sum;
  fbfl_pkg::addr_t       rem_bytes;
  logic [SW-1:0]         need;
  logic [SW:0]           trial;
  logic                  trial_ge;
  logic [DW-1:0]         quot_cap;
  logic                  quot_over;
  fbfl_pkg::count_t      quot_n;

  // The sequencer takes one transaction at a time, so a write to the stack in the
  // accepting cycle of a free and any later read never meet on the same entry.
  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign list_full  = (depth >= fbfl_pkg::MAX_COUNT);
  assign list_empty = (depth == '0);
  // A finished result moves into the output register in this cycle.
  assign out_load   = out_free && ((state == S_ARD) || (state == S_FIN));

  // Grow, step one: the aligned byte position before alignment.
  assign s_sum  = {1'b0, g_start} + {{(AW + 1 - SW){1'b0}}, g_off};
  assign g1_bad = (g_off >= block_size) || s_sum[AW] || (s_sum[AW-1:0] > g_end);

  // Grow, step two: round up to the alignment.
  assign amask = ~({AW{1'b1}} << g_lg);
  assign adj   = (~g_s + 1'b1) & amask;
  assign a_sum = {1'b0, g_s} + {1'b0, adj};

  // Grow, step three: room for at least one whole block from the aligned byte.
  assign rem_bytes = g_end - g_s;
  assign need      = block_size - g_off - 1'b1;

  // Divider step and the capped block count.
  assign trial    = {drem, dvd[DW-1]};
  assign trial_ge = (trial >= {1'b0, block_size});
  assign quot_cap = DW'(fbfl_pkg::MAX_BLOCKS);
  assign quot_over = (dvd > quot_cap);
  assign quot_n   = quot_over ? fbfl_pkg::MAX_COUNT : dvd[CW-1:0];

  // Stack memory port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = depth[IW-1:0];
    ram_wdata = block_address;
    if (state == S_FILL) begin
      ram_we    = 1'b1;
      ram_waddr = fill_idx;
      ram_wdata = fill_addr;
    end else if (accept && (operation == fbfl_pkg::OP_FREE) && !list_full) begin
      ram_we = 1'b1;
    end
  end

  assign ram_raddr = IW'(depth - 1'b1);

  fbfl_ram #(
    .WIDTH(AW),
    .DEPTH(fbfl_pkg::MAX_BLOCKS)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= fbfl_pkg::BLOCK_SIZE_RESET;
    end else if (cfg_we) begin
      block_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      depth     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            res_addr <= '0;
            case (operation)
              fbfl_pkg::OP_GROW: begin
                g_start <= region_start;
                g_end   <= region_end;
                g_lg    <= alignment_log2;
                g_off   <= align_offset;
                state   <= S_G1;
              end
              fbfl_pkg::OP_ALLOC: begin
                if (list_empty) begin
                  res_status <= fbfl_pkg::ST_EMPTY;
                  state      <= S_FIN;
                end else begin
                  // The head is read at the old depth minus one this cycle.
                  res_status <= fbfl_pkg::ST_OK;
                  depth      <= depth - 1'b1;
                  state      <= S_ARD;
                end
              end
              fbfl_pkg::OP_FREE: begin
                if (list_full) begin
                  res_status <= fbfl_pkg::ST_OVERFLOW;
                end else begin
                  res_status <= fbfl_pkg::ST_OK;
                  depth      <= depth + 1'b1;
                end
                state <= S_FIN;
              end
              fbfl_pkg::OP_CLEAR: begin
                res_status <= fbfl_pkg::ST_OK;
                depth      <= '0;
                state      <= S_FIN;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        S_ARD: begin
          if (out_free) begin
            result_address <= ram_rdata;
            status         <= fbfl_pkg::ST_OK;
            free_count     <= depth;
            state          <= S_IDLE;
          end else begin
            res_addr <= ram_rdata;
            state    <= S_FIN;
          end
        end

        S_FIN: begin
          if (out_free) begin
            result_address <= res_addr;
            status         <= res_status;
            free_count     <= depth;
            state          <= S_IDLE;
          end
        end

        S_G1: begin
          g_s <= s_sum[AW-1:0];
          if (g1_bad) begin
            res_status <= fbfl_pkg::ST_BADREGION;
            state      <= S_FIN;
          end else begin
            state <= S_G2;
          end
        end

        S_G2: begin
          g_s <= a_sum[AW-1:0];
          if (a_sum > {1'b0, g_end}) begin
            res_status <= fbfl_pkg::ST_BADREGION;
            state      <= S_FIN;
          end else begin
            state <= S_G3;
          end
        end

        S_G3: begin
          g_first <= g_s - {{(AW - SW){1'b0}}, g_off};
          if (rem_bytes < {{(AW - SW){1'b0}}, need}) begin
            res_status <= fbfl_pkg::ST_BADREGION;
            state      <= S_FIN;
          end else begin
            state <= S_G4;
          end
        end

        S_G4: begin
          // Region length in bytes, end inclusive.
          dvd     <= {1'b0, g_end} - {1'b0, g_first} + 1'b1;
          drem    <= '0;
          div_cnt <= DCW'(DW - 1);
          state   <= S_DIV;
        end

        S_DIV: begin
          drem <= trial_ge ? SW'(trial - {1'b0, block_size}) : trial[SW-1:0];
          dvd  <= {dvd[DW-2:0], trial_ge};
          if (div_cnt == '0) begin
            state <= S_GN;
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end

        S_GN: begin
          // The checks above guarantee at least one block here.
          g_trunc   <= quot_over;
          fill_n    <= quot_n;
          fill_idx  <= IW'(quot_n - 1'b1);
          fill_addr <= g_first;
          state     <= S_FILL;
        end

        S_FILL: begin
          fill_addr <= fill_addr + {{(AW - SW){1'b0}}, block_size};
          if (fill_idx == '0) begin
            depth      <= fill_n;
            res_status <= g_trunc ? fbfl_pkg::ST_TRUNC : fbfl_pkg::ST_OK;
            state      <= S_FIN;
          end else begin
            fill_idx <= fill_idx - 1'b1;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### design/fbfl_ram.sv
module fbfl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/fbfl_checker.sv
`include "fixed_block_free_list_core_defines.svh"

module fbfl_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [fbfl_pkg::ADDR_BITS-1:0]  result_address,
  input logic [fbfl_pkg::STAT_BITS-1:0]  status,
  input logic [fbfl_pkg::COUNT_BITS-1:0] free_count
);

  // One transaction at a time: the input closes right after an acceptance.
  `FBFL_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall)

  `FBFL_ASSERT_NOW(a_count_bound, out_valid, free_count <= fbfl_pkg::MAX_COUNT)

  `FBFL_ASSERT_NOW(a_empty_result, out_valid && (status == fbfl_pkg::ST_EMPTY), (free_count == '0) && (result_address == '0))

  `FBFL_ASSERT_NOW(a_trunc_full, out_valid && (status == fbfl_pkg::ST_TRUNC), free_count == fbfl_pkg::MAX_COUNT)

  `FBFL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result_address) && $stable(status) && $stable(free_count))

endmodule

bind fixed_block_free_list_core fbfl_checker u_fbfl_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .result_address(result_address),
  .status        (status),
  .free_count    (free_count)
);
